### rtl/core/qvt_pkg.sv
// ----------------------------------------------------------------------------
// qvt_pkg: shared types and constants of the quorum vote tracker
// Field widths, function and status codes, register indexes and beat types.
// ----------------------------------------------------------------------------
package qvt_pkg;

  localparam int unsigned MAX_MEMBERS = 5;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned TS_W = 63;
  localparam int unsigned VER_W = 64;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // function codes
  localparam logic [1:0] FUNC_PREPARE = 2'd0;
  localparam logic [1:0] FUNC_ACCEPT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // vote status codes
  localparam logic [2:0] ST_BELOW = 3'd0;
  localparam logic [2:0] ST_EXACT = 3'd1;
  localparam logic [2:0] ST_OVER = 3'd2;
  localparam logic [2:0] ST_NOT_MEMBER = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REPLICA_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_ADDR_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_VERSION = 3'd6;

  typedef struct packed {
    logic [1:0] func;
    logic [ADDR_W-1:0] sender_addr;
    logic [TS_W-1:0] lease_start_ts;
    logic [TS_W-1:0] lease_interval;
    logic [VER_W-1:0] response_version;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] vote_status;
    logic [TS_W-1:0] majority_promised_ts;
    logic synced_with_majority;
  } out_beat_t;

  // command broadcast from the controller to every member cell
  typedef struct packed {
    logic clear;
    logic prep;
    logic acc;
    logic [TS_W-1:0] ts;
    logic [VER_W-1:0] ver;
  } cell_cmd_t;

endpackage

### rtl/core/qvt_cell.sv
// ----------------------------------------------------------------------------
// qvt_cell: one member slot of the vote tracker chain
// Holds the slot's address, ok bit, promised timestamp and version. Match
// claims pass down the chain (lowest active matching slot wins); counts are
// accumulated cell to cell.
// ----------------------------------------------------------------------------
module qvt_cell
  import qvt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic addr_we,
  input  logic [ADDR_W-1:0] addr_wdata,
  input  logic active,
  input  logic [ADDR_W-1:0] sender,
  input  logic claim_in,
  output logic claim_out,
  output logic hit,
  input  logic update,
  input  cell_cmd_t cmd,
  input  logic [VER_W-1:0] cur_ver,
  input  logic [CNT_W-1:0] ok_cnt_in,
  input  logic [CNT_W-1:0] ts_cnt_in,
  input  logic [CNT_W-1:0] ver_cnt_in,
  output logic [CNT_W-1:0] ok_cnt_out,
  output logic [CNT_W-1:0] ts_cnt_out,
  output logic [CNT_W-1:0] ver_cnt_out,
  output logic [TS_W-1:0] ts_val
);

  logic [ADDR_W-1:0] addr_r;
  logic ok_r;
  logic [TS_W-1:0] ts_r;
  logic [VER_W-1:0] ver_r;

  // match and claim chain
  assign hit = active && !claim_in && (addr_r == sender);
  assign claim_out = claim_in || hit;

  // count chain over active slots
  assign ok_cnt_out = ok_cnt_in + CNT_W'(active && ok_r);
  assign ts_cnt_out = ts_cnt_in + CNT_W'(active && (ts_r != '0));
  assign ver_cnt_out = ver_cnt_in + CNT_W'(active && (ver_r == cur_ver));
  assign ts_val = ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      ok_r <= 1'b0;
      ts_r <= '0;
      ver_r <= '0;
    end else begin
      if (addr_we) begin
        addr_r <= addr_wdata;
      end
      if (update && cmd.clear) begin
        ok_r <= 1'b0;
        ts_r <= '0;
      end else if (update && hit) begin
        if (cmd.prep) begin
          ok_r <= 1'b1;
        end
        if (cmd.acc) begin
          if (cmd.ts > ts_r) ts_r <= cmd.ts;
          if (cmd.ver > ver_r) ver_r <= cmd.ver;
        end
      end
    end
  end

endmodule

### rtl/core/qvt_rank.sv
// ----------------------------------------------------------------------------
// qvt_rank: majority-th largest timestamp over the active slots
// Each slot's rank (how many active slots beat it, ties by slot) is found by
// a compare net, registered, then the slot at the majority rank is picked.
// ----------------------------------------------------------------------------
module qvt_rank
  import qvt_pkg::*;
(
  input  logic clk,
  input  logic [MAX_MEMBERS-1:0] active,
  input  logic [TS_W-1:0] ts [MAX_MEMBERS],
  input  logic [CNT_W-1:0] sel_rank,
  output logic [TS_W-1:0] result
);

  logic [CNT_W-1:0] rank_r [MAX_MEMBERS];
  logic [TS_W-1:0] ts_r [MAX_MEMBERS];
  logic [MAX_MEMBERS-1:0] act_r;

  // rank stage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_MEMBERS; i++) begin
      logic [CNT_W-1:0] r;
      r = '0;
      for (int j = 0; j < MAX_MEMBERS; j++) begin
        if (j != i && active[j] &&
            ((ts[j] > ts[i]) || ((ts[j] == ts[i]) && (j < i)))) begin
          r = r + 1'b1;
        end
      end
      rank_r[i] <= r;
      ts_r[i] <= ts[i];
    end
    act_r <= active;
  end

  // pick stage
  always_comb begin
    result = '0;
    for (int i = 0; i < MAX_MEMBERS; i++) begin
      if (act_r[i] && rank_r[i] == sel_rank) result = ts_r[i];
    end
  end

endmodule

### rtl/core/quorum_vote_tracker_top.sv
// ----------------------------------------------------------------------------
// quorum_vote_tracker_top: vote bookkeeping for a quorum election
// Chain of five member cells, a rank selector and a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  input    | in_start / in_busy   | in_beat (in_beat_t)
//  result   | out_strobe           | out_beat (out_beat_t)
//  config   | cfg_we               | cfg_index, cfg_data
//
// out_strobe rises after these steps, in order: match and cell update,
// count and rank compare, rank pick into the output register. The sequencer
// holds one item at a time, so in_busy is high from each accept until the
// result is registered, and a new item is taken at best as the strobe ends.
// Reset is synchronous, active low, and resets control, cell and config state.
// The receiver cannot stall; out_strobe is high for exactly one cycle per item.
module quorum_vote_tracker_top
  import qvt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_start,
  output logic in_busy,
  input  in_beat_t in_beat,
  output logic out_strobe,
  output out_beat_t out_beat,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD = 2'd1;
  localparam logic [1:0] S_CNT = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [2:0] rc_r;
  logic [VER_W-1:0] cur_ver_r;
  in_beat_t beat_r;
  logic [2:0] n_act;
  logic [2:0] maj;
  logic [MAX_MEMBERS-1:0] active;
  logic [MAX_MEMBERS:0] claim;
  logic [MAX_MEMBERS-1:0] hit;
  logic [CNT_W-1:0] okc [MAX_MEMBERS+1];
  logic [CNT_W-1:0] tsc [MAX_MEMBERS+1];
  logic [CNT_W-1:0] vc [MAX_MEMBERS+1];
  logic [TS_W-1:0] ts_v [MAX_MEMBERS];
  logic [TS_W-1:0] rank_ts;
  logic [TS_W:0] sum;
  cell_cmd_t cmd;
  logic upd;
  logic found_r;
  logic [2:0] status_r;
  logic synced_r;
  logic strobe_r;
  out_beat_t out_r;
  logic accept;

  assign accept = in_start && !in_busy;
  assign in_busy = (state_r != S_IDLE);

  // replica count clamp and majority threshold
  always_comb begin
    n_act = rc_r;
    if (rc_r == 3'd0) n_act = 3'd1;
    if (rc_r > 3'(MAX_MEMBERS)) n_act = 3'(MAX_MEMBERS);
    maj = (n_act >> 1) + 3'd1;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= 3'd3;
      cur_ver_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_REPLICA_COUNT) rc_r <= cfg_data[2:0];
      if (cfg_index == REG_CURRENT_VERSION) cur_ver_r <= cfg_data;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) beat_r <= in_beat;
  end

  // saturated promised timestamp
  assign sum = {1'b0, beat_r.lease_start_ts} + {1'b0, beat_r.lease_interval};
  always_comb begin
    cmd.clear = (beat_r.func == FUNC_CLEAR);
    cmd.prep = (beat_r.func == FUNC_PREPARE);
    cmd.acc = (beat_r.func == FUNC_ACCEPT);
    cmd.ts = sum[TS_W] ? {TS_W{1'b1}} : sum[TS_W-1:0];
    cmd.ver = beat_r.response_version;
  end
  assign upd = (state_r == S_UPD);

  // member cell chain
  assign claim[0] = 1'b0;
  assign okc[0] = '0;
  assign tsc[0] = '0;
  assign vc[0] = '0;
  for (genvar g = 0; g < MAX_MEMBERS; g++) begin : g_cell
    assign active[g] = (3'(g) < n_act);
    qvt_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .addr_we(cfg_we && (cfg_index == REG_MEMBER_ADDR_0 + CFG_IDX_W'(g))),
      .addr_wdata(cfg_data[ADDR_W-1:0]),
      .active(active[g]),
      .sender(beat_r.sender_addr),
      .claim_in(claim[g]), .claim_out(claim[g+1]), .hit(hit[g]),
      .update(upd), .cmd(cmd), .cur_ver(cur_ver_r),
      .ok_cnt_in(okc[g]), .ts_cnt_in(tsc[g]), .ver_cnt_in(vc[g]),
      .ok_cnt_out(okc[g+1]), .ts_cnt_out(tsc[g+1]), .ver_cnt_out(vc[g+1]),
      .ts_val(ts_v[g])
    );
  end

  qvt_rank u_rank (
    .clk(clk), .active(active), .ts(ts_v),
    .sel_rank(n_act >> 1), .result(rank_ts)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_UPD;
      S_UPD: state_nxt = S_CNT;
      S_CNT: state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      strobe_r <= (state_r == S_OUT);
    end
  end

  // status after the cell update
  always_ff @(posedge clk) begin
    if (upd) found_r <= claim[MAX_MEMBERS];
    if (state_r == S_CNT) begin
      synced_r <= (cur_ver_r == '0) || (vc[MAX_MEMBERS] >= maj);
      if (cmd.clear) status_r <= ST_CLEARED;
      else if (!found_r || !(cmd.prep || cmd.acc)) status_r <= ST_NOT_MEMBER;
      else if (cmd.prep) begin
        if (okc[MAX_MEMBERS] < maj) status_r <= ST_BELOW;
        else if (okc[MAX_MEMBERS] > maj) status_r <= ST_OVER;
        else status_r <= ST_EXACT;
      end else begin
        status_r <= (tsc[MAX_MEMBERS] < maj) ? ST_BELOW : ST_EXACT;
      end
    end
    if (state_r == S_OUT) begin
      out_r.vote_status <= status_r;
      out_r.majority_promised_ts <= rank_ts;
      out_r.synced_with_majority <= synced_r;
    end
  end

  assign out_strobe = strobe_r;
  assign out_beat = out_r;

`ifndef SYNTHESIS
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit))
    else $error("more than one slot matched");
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe longer than one cycle");
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_busy) else $error("not busy after accept");
  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !in_busy) else $error("result while busy");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the quorum vote tracker
// A local vote tracker predicts every result beat. It covers prepare, accept,
// clear, unknown senders, the unused function code, replica count extremes,
// timestamp saturation and member list changes, then random election rounds.
// ----------------------------------------------------------------------------
module tb;
  import qvt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_start = 1'b0;
  logic in_busy;
  in_beat_t in_beat = '0;
  logic out_strobe;
  out_beat_t out_beat;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  quorum_vote_tracker_top dut (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
    .in_beat(in_beat), .out_strobe(out_strobe), .out_beat(out_beat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // tracker copy: configuration and per-member vote state
  logic [2:0] replica_reg;
  logic [ADDR_W-1:0] member_addr [MAX_MEMBERS];
  logic [VER_W-1:0] cur_version;
  logic ok_bit [MAX_MEMBERS];
  logic [TS_W-1:0] promise [MAX_MEMBERS];
  logic [VER_W-1:0] fol_version [MAX_MEMBERS];

  out_beat_t vote_queue[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;

  function automatic int active_members();
    int n;
    n = replica_reg;
    if (n < 1) n = 1;
    if (n > MAX_MEMBERS) n = MAX_MEMBERS;
    return n;
  endfunction

  // apply one item to the tracker copy and return its expected result
  function automatic out_beat_t track_vote(in_beat_t b);
    out_beat_t r;
    int n, maj, slot, cnt, rank;
    logic [TS_W:0] sum;
    logic [TS_W-1:0] srt [MAX_MEMBERS];
    logic [TS_W-1:0] x;
    n = active_members();
    maj = n / 2 + 1;
    slot = -1;
    cnt = 0;
    r.vote_status = ST_NOT_MEMBER;
    if (b.func == FUNC_CLEAR) begin
      for (int i = 0; i < MAX_MEMBERS; i++) begin
        ok_bit[i] = 1'b0;
        promise[i] = '0;
      end
      r.vote_status = ST_CLEARED;
    end else if (b.func == FUNC_PREPARE || b.func == FUNC_ACCEPT) begin
      for (int i = n - 1; i >= 0; i--)
        if (member_addr[i] == b.sender_addr) slot = i;
      if (slot >= 0 && b.func == FUNC_PREPARE) begin
        ok_bit[slot] = 1'b1;
        for (int i = 0; i < n; i++) if (ok_bit[i]) cnt++;
        r.vote_status = cnt < maj ? ST_BELOW : (cnt > maj ? ST_OVER : ST_EXACT);
      end else if (slot >= 0) begin
        sum = {1'b0, b.lease_start_ts} + {1'b0, b.lease_interval};
        if (sum > {1'b0, TS_MAX}) sum = {1'b0, TS_MAX};
        if (sum[TS_W-1:0] > promise[slot]) promise[slot] = sum[TS_W-1:0];
        if (b.response_version > fol_version[slot])
          fol_version[slot] = b.response_version;
        for (int i = 0; i < n; i++) if (promise[i] != 0) cnt++;
        r.vote_status = cnt < maj ? ST_BELOW : ST_EXACT;
      end
    end
    // descending insertion sort, then pick the majority rank
    for (int i = 0; i < n; i++) srt[i] = promise[i];
    for (int i = 1; i < n; i++) begin
      x = srt[i];
      rank = i;
      while (rank > 0 && srt[rank-1] < x) begin
        srt[rank] = srt[rank-1];
        rank--;
      end
      srt[rank] = x;
    end
    r.majority_promised_ts = srt[n/2];
    cnt = 0;
    for (int i = 0; i < n; i++) if (fol_version[i] == cur_version) cnt++;
    r.synced_with_majority = (cur_version == 0) || (cnt >= maj);
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_beat_t exp_b;
    if (rst_n && out_strobe) begin
      if (vote_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_beat);
        errors++;
      end else begin
        exp_b = vote_queue.pop_front();
        beats_checked++;
        if (exp_b.vote_status !== out_beat.vote_status) begin
          $display("%0t: vote_status exp %0d got %0d", $time,
                   exp_b.vote_status, out_beat.vote_status);
          errors++;
        end
        if (exp_b.majority_promised_ts !== out_beat.majority_promised_ts) begin
          $display("%0t: majority_promised_ts exp %h got %h", $time,
                   exp_b.majority_promised_ts, out_beat.majority_promised_ts);
          errors++;
        end
        if (exp_b.synced_with_majority !== out_beat.synced_with_majority) begin
          $display("%0t: synced_with_majority exp %b got %b", $time,
                   exp_b.synced_with_majority, out_beat.synced_with_majority);
          errors++;
        end
      end
    end
  end

  // send one beat; start stays high until accepted, then goes low
  task automatic send_vote(in_beat_t b);
    while (idle_on && $urandom_range(99) < 33) @(posedge clk);
    in_start <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (in_busy) @(posedge clk);
    vote_queue.push_back(track_vote(b));
    beats_sent++;
    in_start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (vote_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REPLICA_COUNT) replica_reg = val[2:0];
    else if (idx == REG_CURRENT_VERSION) cur_version = val;
    else if (idx <= REG_MEMBER_ADDR_0 + MAX_MEMBERS - 1)
      member_addr[idx - REG_MEMBER_ADDR_0] = val[ADDR_W-1:0];
    @(posedge clk);
  endtask

  function automatic in_beat_t make_beat(logic [1:0] f, logic [ADDR_W-1:0] a,
                                         logic [TS_W-1:0] s, logic [TS_W-1:0] l,
                                         logic [VER_W-1:0] v);
    in_beat_t b;
    b.func = f;
    b.sender_addr = a;
    b.lease_start_ts = s;
    b.lease_interval = l;
    b.response_version = v;
    return b;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic set_members(int count);
    write_reg(REG_REPLICA_COUNT, CFG_W'(count));
    for (int i = 0; i < MAX_MEMBERS; i++)
      write_reg(CFG_IDX_W'(REG_MEMBER_ADDR_0 + i), rand64());
  endtask

  // directed: edges of every field, each function, each special case
  task automatic test_directed();
    write_reg(REG_REPLICA_COUNT, 3);
    write_reg(REG_MEMBER_ADDR_0, '0);
    write_reg(CFG_IDX_W'(REG_MEMBER_ADDR_0 + 1), 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_IDX_W'(REG_MEMBER_ADDR_0 + 2), 48'h0A00_0001_1F90);
    write_reg(CFG_IDX_W'(REG_MEMBER_ADDR_0 + 3), 48'h1234);
    write_reg(CFG_IDX_W'(REG_MEMBER_ADDR_0 + 4), 48'h5678);
    write_reg(REG_CURRENT_VERSION, 64'hFFFF_FFFF_FFFF_FFFF);
    send_vote(make_beat(FUNC_PREPARE, '0, '0, '0, '0));
    send_vote(make_beat(FUNC_PREPARE, '0, '0, '0, '0));
    send_vote(make_beat(FUNC_PREPARE, 48'hFFFF_FFFF_FFFF, TS_MAX, TS_MAX, '1));
    send_vote(make_beat(FUNC_PREPARE, 48'h0A00_0001_1F90, '0, '0, '0));
    send_vote(make_beat(FUNC_PREPARE, 48'h1234, '0, '0, '0));  // slot beyond n
    send_vote(make_beat(FUNC_PREPARE, 48'hBEEF, '0, '0, '0));  // unknown sender
    send_vote(make_beat(FUNC_ACCEPT, '0, TS_MAX, TS_MAX, '1)); // saturation
    send_vote(make_beat(FUNC_ACCEPT, 48'hFFFF_FFFF_FFFF, 5, 0, 64'd7));
    send_vote(make_beat(FUNC_ACCEPT, 48'hFFFF_FFFF_FFFF, 1, 1, '1));
    send_vote(make_beat(FUNC_ACCEPT, 48'h0A00_0001_1F90, 0, 0, '0));
    send_vote(make_beat(FUNC_ACCEPT, 48'h0A00_0001_1F90, 100, 23, '1));
    send_vote(make_beat(FUNC_UNUSED, '0, TS_MAX, TS_MAX, '1));
    send_vote(make_beat(FUNC_CLEAR, '0, '0, '0, '0));
    drain();
    // replica count zero acts as one, above max acts as max
    write_reg(REG_REPLICA_COUNT, 0);
    send_vote(make_beat(FUNC_ACCEPT, '0, 9, 9, '1));
    send_vote(make_beat(FUNC_PREPARE, '0, '0, '0, '0));
    drain();
    write_reg(REG_REPLICA_COUNT, 7);
    write_reg(REG_CURRENT_VERSION, '0);
    for (int i = 0; i < MAX_MEMBERS; i++)
      send_vote(make_beat(FUNC_PREPARE, i == 0 ? 48'h0 : (i == 1 ? 48'hFFFF_FFFF_FFFF :
        (i == 2 ? 48'h0A00_0001_1F90 : (i == 3 ? 48'h1234 : 48'h5678))), 0, 0, 0));
    send_vote(make_beat(FUNC_ACCEPT, 48'h5678, TS_MAX, 0, 64'h1));
    send_vote(make_beat(FUNC_CLEAR, ADDR_W'(rand64()), TS_W'(rand64()),
                        TS_W'(rand64()), rand64()));
    drain();
  endtask

  // random election rounds over changing member lists
  task automatic test_random_rounds(int total);
    in_beat_t b;
    int n, pick, phase;
    logic [VER_W-1:0] vers [3];
    phase = 0;
    while (beats_sent < total) begin
      drain();
      n = (phase % 4 == 0) ? $urandom_range(7) : $urandom_range(5, 1);
      set_members(n);
      for (int i = 0; i < 3; i++) vers[i] = ($urandom_range(3) == 0) ? rand64() :
                                             VER_W'($urandom_range(3));
      write_reg(REG_CURRENT_VERSION, vers[$urandom_range(2)]);
      idle_on = (phase % 5 != 3);
      for (int k = 0; k < 40; k++) begin
        b = make_beat(FUNC_PREPARE, '0, TS_W'(rand64()), TS_W'(rand64()),
                      vers[$urandom_range(2)]);
        pick = $urandom_range(99);
        b.func = pick < 40 ? FUNC_PREPARE : (pick < 85 ? FUNC_ACCEPT :
                 (pick < 93 ? FUNC_CLEAR : FUNC_UNUSED));
        if ($urandom_range(9) < 8) b.sender_addr = member_addr[$urandom_range(4)];
        else b.sender_addr = ADDR_W'(rand64());
        case ($urandom_range(3))
          0: begin
            b.lease_start_ts = TS_W'($urandom_range(1000));
            b.lease_interval = TS_W'($urandom_range(1000));
          end
          1: b.lease_interval = '0;
          default: ;
        endcase
        if ($urandom_range(7) == 0) b.response_version = rand64();
        send_vote(b);
        if (beats_sent >= total) break;
      end
      phase++;
    end
    idle_on = 1'b1;
    drain();
  endtask

  initial begin
    replica_reg = 3;
    cur_version = '0;
    for (int i = 0; i < MAX_MEMBERS; i++) begin
      member_addr[i] = '0;
      ok_bit[i] = 1'b0;
      promise[i] = '0;
      fol_version[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_rounds(1620);
    $display("covered %0d beats, %0d results checked, replica counts 0..7,",
             beats_sent, beats_checked);
    $display("clears, unknown senders, unused code and timestamp saturation");
    if (errors == 0 && vote_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d results missing", errors, vote_queue.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
